FILE: sv/awmps_pkg.sv
// Shared types, constants and helper functions for the area weighted mesh point sampler.
package awmps_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int MAX_FACES    = 4096;
    localparam int VADDR_W      = $clog2(MAX_VERTICES);
    localparam int FADDR_W      = $clog2(MAX_FACES);
    localparam int CNT_W        = FADDR_W + 1;
    localparam int CUM_W        = 44;
    localparam int POS_W        = 24;
    localparam int NRM_W        = 16;
    localparam int W_W          = 17;
    localparam int PACC_W       = 44;
    localparam int NACC_W       = 35;
    localparam int IN_TDATA_W   = 120;
    localparam int OUT_TDATA_W  = 136;

    localparam logic [W_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_POS    = 3'd1,
        ACT_NORMAL = 3'd2,
        ACT_FACE   = 3'd3,
        ACT_SAMPLE = 3'd4
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TARGET,
        ST_TARGET_HI,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_FACE_RD,
        ST_FACE_WAIT,
        ST_VERT_RD,
        ST_VERT_MUL,
        ST_VERT_ACC,
        ST_NORM_START,
        ST_NORM_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        NS_IDLE,
        NS_SQ,
        NS_SQRT,
        NS_DIV,
        NS_DONE
    } nstate_t;

    function automatic logic [15:0] sat_u16(input logic signed [23:0] v);
        logic [15:0] r;
        if (v < 0)
            r = 16'd0;
        else if (v > 24'sd65535)
            r = 16'hFFFF;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic [15:0] sat_s16(input logic signed [23:0] v);
        logic [15:0] r;
        if (v < -24'sd32768)
            r = 16'h8000;
        else if (v > 24'sd32767)
            r = 16'h7FFF;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic [POS_W-1:0] round_pos(input logic signed [PACC_W-1:0] acc);
        logic signed [PACC_W:0]    s;
        logic signed [PACC_W-16:0] sh;
        logic [POS_W-1:0]          r;
        s  = $signed({acc[PACC_W-1], acc}) + $signed((PACC_W+1)'(32768));
        sh = (PACC_W-15)'(s >>> 16);
        if (sh < -(PACC_W-15)'(8388608))
            r = 24'h800000;
        else if (sh > (PACC_W-15)'(8388607))
            r = 24'h7FFFFF;
        else
            r = sh[POS_W-1:0];
        return r;
    endfunction

endpackage

FILE: sv/awmps_ram.sv
// Generic single write port, single read port RAM with registered read data.
module awmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/awmps_norm.sv
// Normal normalization unit: sum of squares, bit-serial square root, three restoring dividers.
module awmps_norm (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2:0][34:0] nrm,
    output logic             done,
    output logic [2:0][15:0] norm
);

    awmps_pkg::nstate_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] mag_reg [3];
    logic [31:0] mag_next [3];
    logic        neg_reg [3];
    logic        neg_next [3];
    logic [63:0] sq_reg, sq_next;
    logic [63:0] sqsh_reg, sqsh_next;
    logic [34:0] srem_reg, srem_next;
    logic [31:0] root_reg, root_next;
    logic [33:0] drem_reg [3];
    logic [33:0] drem_next [3];
    logic [14:0] nlow_reg [3];
    logic [14:0] nlow_next [3];
    logic [14:0] quo_reg [3];
    logic [14:0] quo_next [3];

    logic [34:0] s_try;
    logic [34:0] s_trial;
    logic [46:0] num [3];
    logic [32:0] dvs;
    logic [33:0] d_try [3];
    logic [34:0] nabs [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= awmps_pkg::NS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        sq_reg   <= sq_next;
        sqsh_reg <= sqsh_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        for (int i = 0; i < 3; i++)
        begin
            mag_reg[i]  <= mag_next[i];
            neg_reg[i]  <= neg_next[i];
            drem_reg[i] <= drem_next[i];
            nlow_reg[i] <= nlow_next[i];
            quo_reg[i]  <= quo_next[i];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sq_next    = sq_reg;
        sqsh_next  = sqsh_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        s_try      = {srem_reg[32:0], sqsh_reg[63:62]};
        s_trial    = {1'b0, root_reg, 2'b01};
        dvs        = {root_reg, 1'b0};
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i]  = mag_reg[i];
            neg_next[i]  = neg_reg[i];
            drem_next[i] = drem_reg[i];
            nlow_next[i] = nlow_reg[i];
            quo_next[i]  = quo_reg[i];
            nabs[i]      = nrm[i][34] ? 35'(-$signed(nrm[i])) : nrm[i];
            num[i]       = {mag_reg[i], 15'd0} + 47'(root_reg);
            d_try[i]     = {drem_reg[i][32:0], nlow_reg[i][14]};
        end
        done = 1'b0;

        case (state_reg)
            awmps_pkg::NS_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = nabs[i][31:0];
                        neg_next[i] = nrm[i][34];
                    end
                    sq_next    = 64'd0;
                    cnt_next   = 5'd0;
                    state_next = awmps_pkg::NS_SQ;
                end
            end
            awmps_pkg::NS_SQ:
            begin
                sq_next  = sq_reg + 64'(mag_reg[cnt_reg[1:0]] * mag_reg[cnt_reg[1:0]]);
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg[1:0] == 2'd2)
                begin
                    cnt_next   = 5'd0;
                    sqsh_next  = sq_next;
                    srem_next  = 35'd0;
                    root_next  = 32'd0;
                    state_next = awmps_pkg::NS_SQRT;
                end
            end
            awmps_pkg::NS_SQRT:
            begin
                sqsh_next = {sqsh_reg[61:0], 2'b00};
                if (s_try >= s_trial)
                begin
                    srem_next = s_try - s_trial;
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    srem_next = s_try;
                    root_next = {root_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    cnt_next   = 5'd0;
                    state_next = awmps_pkg::NS_DIV;
                end
            end
            awmps_pkg::NS_DIV:
            begin
                if (cnt_reg == 5'd0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        drem_next[i] = {2'b00, num[i][46:15]};
                        nlow_next[i] = num[i][14:0];
                        quo_next[i]  = 15'd0;
                    end
                    cnt_next = 5'd1;
                    if (root_reg == 32'd0)
                    begin
                        state_next = awmps_pkg::NS_DONE;
                    end
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        nlow_next[i] = {nlow_reg[i][13:0], 1'b0};
                        if (d_try[i] >= {1'b0, dvs})
                        begin
                            drem_next[i] = d_try[i] - {1'b0, dvs};
                            quo_next[i]  = {quo_reg[i][13:0], 1'b1};
                        end
                        else
                        begin
                            drem_next[i] = d_try[i];
                            quo_next[i]  = {quo_reg[i][13:0], 1'b0};
                        end
                    end
                    cnt_next = cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15)
                    begin
                        state_next = awmps_pkg::NS_DONE;
                    end
                end
            end
            awmps_pkg::NS_DONE:
            begin
                done       = 1'b1;
                state_next = awmps_pkg::NS_IDLE;
            end
            default:
            begin
                state_next = awmps_pkg::NS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (root_reg == 32'd0)
                norm[i] = 16'd0;
            else if (neg_reg[i])
                norm[i] = 16'(-$signed({1'b0, quo_reg[i]}));
            else
                norm[i] = {1'b0, quo_reg[i]};
        end
    end

endmodule

FILE: sv/area_weighted_mesh_point_sampler.sv
// Top level of the area weighted mesh point sampler: mesh tables, face search and interpolation.
//
//  channel | dir | tdata                                  | tuser
//  s_      | in  | index, value_a, value_b, value_c, area | action
//  m_      | out | pos_x/y/z, norm_x/y/z, face_chosen     | error
//
// Loads and clears do not leave the idle state; s_tready stays high for them.
// A sample holds s_tready low while it runs the key product in two halves, the search
// steps (a read and a compare each, plus a final check), the face read, the vertex reads,
// a start, the normal unit (3 squares, 32 root steps, the divider steps, done; the divider
// steps are skipped for a zero normal) and the load of the output register.
// An error sample skips to ST_OUT. rst_n clears only the face count, area total and control.
// A result waits in the output register while loads are accepted; a sample stalls there.
module area_weighted_mesh_point_sampler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [awmps_pkg::IN_TDATA_W-1:0]  s_tdata,  // index, value_a, value_b, value_c, area, pad
    input  logic [2:0]                        s_tuser,  // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [awmps_pkg::OUT_TDATA_W-1:0] m_tdata,  // pos_x/y/z, norm_x/y/z, face_chosen, pad
    output logic                              m_tuser   // error
);

    localparam int VW = awmps_pkg::VADDR_W;
    localparam int FW = awmps_pkg::FADDR_W;

    awmps_pkg::state_t state_reg, state_next;
    logic [awmps_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [awmps_pkg::CUM_W-1:0]       total_reg, total_next;
    logic [15:0]                       key_reg, key_next;
    logic [16:0]                       w_reg [3];
    logic [16:0]                       w_next [3];
    logic [59:0]                       target_reg, target_next;
    logic [FW-1:0]                     lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [2:0][11:0]                  corners_reg, corners_next;
    logic [1:0]                        ci_reg, ci_next;
    logic signed [41:0]                pprod_reg [3];
    logic signed [41:0]                pprod_next [3];
    logic signed [33:0]                nprod_reg [3];
    logic signed [33:0]                nprod_next [3];
    logic signed [awmps_pkg::PACC_W-1:0] pacc_reg [3];
    logic signed [awmps_pkg::PACC_W-1:0] pacc_next [3];
    logic signed [awmps_pkg::NACC_W-1:0] nacc_reg [3];
    logic signed [awmps_pkg::NACC_W-1:0] nacc_next [3];
    logic                              err_reg, err_next;
    logic                              out_valid_reg, out_valid_next;
    logic [awmps_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                              out_err_reg, out_err_next;

    logic                              accept;
    logic [11:0]                       in_index;
    logic signed [23:0]                in_a, in_b, in_c;
    logic [31:0]                       in_area;
    logic [15:0]                       sw0, sw1;
    logic [16:0]                       wsum;

    logic                              pos_we, nrm_we, face_we;
    logic [VW-1:0]                     vraddr;
    logic [71:0]                       pos_rd;
    logic [47:0]                       nrm_rd;
    logic [FW-1:0]                     fraddr;
    logic [35:0]                       face_rd;
    logic [awmps_pkg::CUM_W-1:0]       cum_rd;
    logic [awmps_pkg::CUM_W-1:0]       cum_wdata;

    logic                              nu_start, nu_done;
    logic [2:0][awmps_pkg::NACC_W-1:0] nu_in;
    logic [2:0][awmps_pkg::NRM_W-1:0]  nu_norm;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == awmps_pkg::ST_IDLE);
    assign in_index = s_tdata[11:0];
    assign in_a     = $signed(s_tdata[35:12]);
    assign in_b     = $signed(s_tdata[59:36]);
    assign in_c     = $signed(s_tdata[83:60]);
    assign in_area  = s_tdata[115:84];
    assign sw0      = awmps_pkg::sat_u16(in_b);
    assign sw1      = awmps_pkg::sat_u16(in_c);
    assign wsum     = {1'b0, sw0} + {1'b0, sw1};

    assign pos_we    = accept && (s_tuser == awmps_pkg::ACT_POS);
    assign nrm_we    = accept && (s_tuser == awmps_pkg::ACT_NORMAL);
    assign face_we   = accept && (s_tuser == awmps_pkg::ACT_FACE)
                       && (count_reg < awmps_pkg::CNT_W'(awmps_pkg::MAX_FACES));
    assign cum_wdata = total_reg + awmps_pkg::CUM_W'(in_area);

    awmps_ram #(.WIDTH(72), .DEPTH(awmps_pkg::MAX_VERTICES)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (in_index[VW-1:0]),
        .wdata ({in_c, in_b, in_a}),
        .raddr (vraddr),
        .rdata (pos_rd)
    );

    awmps_ram #(.WIDTH(48), .DEPTH(awmps_pkg::MAX_VERTICES)) u_nrm_ram (
        .clk   (clk),
        .we    (nrm_we),
        .waddr (in_index[VW-1:0]),
        .wdata ({awmps_pkg::sat_s16(in_c), awmps_pkg::sat_s16(in_b), awmps_pkg::sat_s16(in_a)}),
        .raddr (vraddr),
        .rdata (nrm_rd)
    );

    awmps_ram #(.WIDTH(36), .DEPTH(awmps_pkg::MAX_FACES)) u_face_ram (
        .clk   (clk),
        .we    (face_we),
        .waddr (count_reg[FW-1:0]),
        .wdata ({in_c[11:0], in_b[11:0], in_a[11:0]}),
        .raddr (fraddr),
        .rdata (face_rd)
    );

    awmps_ram #(.WIDTH(awmps_pkg::CUM_W), .DEPTH(awmps_pkg::MAX_FACES)) u_cum_ram (
        .clk   (clk),
        .we    (face_we),
        .waddr (count_reg[FW-1:0]),
        .wdata (cum_wdata),
        .raddr (mid_next),
        .rdata (cum_rd)
    );

    assign fraddr = lo_reg;
    assign vraddr = corners_reg[ci_reg][VW-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nu_in[i] = nacc_reg[i];
        end
    end

    awmps_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (nu_start),
        .nrm   (nu_in),
        .done  (nu_done),
        .norm  (nu_norm)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= awmps_pkg::ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        target_reg   <= target_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        corners_reg  <= corners_next;
        ci_reg       <= ci_next;
        err_reg      <= err_next;
        out_data_reg <= out_data_next;
        out_err_reg  <= out_err_next;
        for (int i = 0; i < 3; i++)
        begin
            w_reg[i]     <= w_next[i];
            pprod_reg[i] <= pprod_next[i];
            nprod_reg[i] <= nprod_next[i];
            pacc_reg[i]  <= pacc_next[i];
            nacc_reg[i]  <= nacc_next[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        key_next       = key_reg;
        target_next    = target_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        corners_next   = corners_reg;
        ci_next        = ci_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_err_next   = out_err_reg;
        nu_start       = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            w_next[i]     = w_reg[i];
            pprod_next[i] = pprod_reg[i];
            nprod_next[i] = nprod_reg[i];
            pacc_next[i]  = pacc_reg[i];
            nacc_next[i]  = nacc_reg[i];
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            awmps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        awmps_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        awmps_pkg::ACT_FACE:
                        begin
                            if (face_we)
                            begin
                                count_next = count_reg + 1'b1;
                                total_next = cum_wdata;
                            end
                        end
                        awmps_pkg::ACT_SAMPLE:
                        begin
                            key_next = awmps_pkg::sat_u16(in_a);
                            if (wsum > awmps_pkg::ONE_Q16)
                            begin
                                w_next[0] = awmps_pkg::ONE_Q16 - {1'b0, sw0};
                                w_next[1] = awmps_pkg::ONE_Q16 - {1'b0, sw1};
                            end
                            else
                            begin
                                w_next[0] = {1'b0, sw0};
                                w_next[1] = {1'b0, sw1};
                            end
                            w_next[2] = awmps_pkg::ONE_Q16 - w_next[0] - w_next[1];
                            lo_next   = '0;
                            hi_next   = FW'(count_reg - 1'b1);
                            if (count_reg == '0 || total_reg == '0)
                            begin
                                err_next   = 1'b1;
                                state_next = awmps_pkg::ST_OUT;
                            end
                            else
                            begin
                                err_next   = 1'b0;
                                state_next = awmps_pkg::ST_TARGET;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            awmps_pkg::ST_TARGET:
            begin
                // key * total in two 16x22 halves
                target_next = 60'(key_reg * total_reg[21:0]);
                state_next  = awmps_pkg::ST_TARGET_HI;
            end
            awmps_pkg::ST_TARGET_HI:
            begin
                target_next = target_reg + {38'(key_reg * total_reg[43:22]), 22'd0};
                state_next  = awmps_pkg::ST_SRCH_RD;
            end
            awmps_pkg::ST_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = lo_reg + ((hi_reg - lo_reg) >> 1);
                    state_next = awmps_pkg::ST_SRCH_CMP;
                end
                else
                begin
                    state_next = awmps_pkg::ST_FACE_RD;
                end
            end
            awmps_pkg::ST_SRCH_CMP:
            begin
                if ({cum_rd, 16'd0} >= target_reg)
                    hi_next = mid_reg;
                else
                    lo_next = mid_reg + 1'b1;
                state_next = awmps_pkg::ST_SRCH_RD;
            end
            awmps_pkg::ST_FACE_RD:
            begin
                state_next = awmps_pkg::ST_FACE_WAIT;
            end
            awmps_pkg::ST_FACE_WAIT:
            begin
                corners_next = face_rd;
                ci_next      = 2'd0;
                for (int i = 0; i < 3; i++)
                begin
                    pacc_next[i] = '0;
                    nacc_next[i] = '0;
                end
                state_next = awmps_pkg::ST_VERT_RD;
            end
            awmps_pkg::ST_VERT_RD:
            begin
                state_next = awmps_pkg::ST_VERT_MUL;
            end
            awmps_pkg::ST_VERT_MUL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pprod_next[i] = $signed({1'b0, w_reg[ci_reg]}) * $signed(pos_rd[24*i +: 24]);
                    nprod_next[i] = $signed({1'b0, w_reg[ci_reg]}) * $signed(nrm_rd[16*i +: 16]);
                end
                state_next = awmps_pkg::ST_VERT_ACC;
            end
            awmps_pkg::ST_VERT_ACC:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pacc_next[i] = pacc_reg[i] + awmps_pkg::PACC_W'(pprod_reg[i]);
                    nacc_next[i] = nacc_reg[i] + awmps_pkg::NACC_W'(nprod_reg[i]);
                end
                ci_next = ci_reg + 2'd1;
                if (ci_reg == 2'd2)
                    state_next = awmps_pkg::ST_NORM_START;
                else
                    state_next = awmps_pkg::ST_VERT_RD;
            end
            awmps_pkg::ST_NORM_START:
            begin
                nu_start   = 1'b1;
                state_next = awmps_pkg::ST_NORM_WAIT;
            end
            awmps_pkg::ST_NORM_WAIT:
            begin
                if (nu_done)
                    state_next = awmps_pkg::ST_OUT;
            end
            awmps_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_err_next   = err_reg;
                    if (err_reg)
                        out_data_next = '0;
                    else
                        out_data_next = {4'd0, lo_reg,
                                         nu_norm[2], nu_norm[1], nu_norm[0],
                                         awmps_pkg::round_pos(pacc_reg[2]),
                                         awmps_pkg::round_pos(pacc_reg[1]),
                                         awmps_pkg::round_pos(pacc_reg[0])};
                    state_next = awmps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = awmps_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

endmodule

FILE: sv/awmps_checker.sv
// Port-level checker for the area weighted mesh point sampler, bound to the top level.
module awmps_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [119:0] s_tdata,
    input logic [2:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic         m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error result carries nonzero data");

    a_norm_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[87:72]) <= 16'sd16384
                      && $signed(m_tdata[87:72]) >= -16'sd16384))
        else $error("normal x out of unit range");

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == awmps_pkg::ACT_SAMPLE |=> !s_tready)
        else $error("input taken while sample in progress");

endmodule

bind area_weighted_mesh_point_sampler awmps_checker u_awmps_checker (.*);
